FILE: rtl/cmfs_pkg.sv
// Package: shared types and constants for the cube-map face selector.
`timescale 1ns / 1ps
package cmfs_pkg;

    localparam int DIR_W   = 24;
    localparam int COORD_W = 17;
    localparam int ADDR_W  = 32;
    localparam int FACE_W  = 3;
    localparam int NUM_FACES = 6;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    // Result of face selection, before division
    typedef struct packed {
        logic [DIR_W-1:0]  mag_x;
        logic [DIR_W-1:0]  mag_y;
        logic [DIR_W-1:0]  mag_z;
        logic              neg_s;
        logic              neg_t;
        logic [FACE_W-1:0] face;
    } sel_t;

    // Item travelling down the divider chain
    typedef struct packed {
        logic [DIR_W-1:0]  rem_s;
        logic [DIR_W-1:0]  rem_t;
        logic [DIR_W-1:0]  divisor;
        logic              neg_s;
        logic              neg_t;
        logic [FACE_W-1:0] face;
        logic [ADDR_W-1:0] addr;
    } work_t;

endpackage

FILE: rtl/cmfs_if.sv
// Interfaces: direction input channel and result output channel.
`timescale 1ns / 1ps
interface cmfs_dir_if;
    logic              valid;
    logic              ready;
    logic signed [23:0] dir_u;
    logic signed [23:0] dir_v;
    logic signed [23:0] dir_w;

    modport source (output valid, output dir_u, output dir_v, output dir_w, input ready);
    modport sink   (input valid, input dir_u, input dir_v, input dir_w, output ready);
endinterface

interface cmfs_res_if;
    logic        valid;
    logic        ready;
    logic [16:0] coord_s;
    logic [16:0] coord_t;
    logic [23:0] major_abs;
    logic [2:0]  face_index;
    logic [31:0] face_address;

    modport source (output valid, output coord_s, output coord_t, output major_abs,
                    output face_index, output face_address, input ready);
    modport sink   (input valid, input coord_s, input coord_t, input major_abs,
                    input face_index, input face_address, output ready);
endinterface

FILE: rtl/cube_map_face_select.sv
// Top level: cube-map face selection and projection pipeline.
`timescale 1ns / 1ps
// Takes one direction item per cycle while not stalled and returns one result
// item per input, in order. The item passes an input register holding the face
// choice, a chain of COORD_FRAC_BITS division cells (one quotient bit for both
// s and t per cell) and an output register. The whole pipeline advances
// together; it halts only while the output register holds an item not yet
// taken, so ready follows the output side. Base addresses are sampled when an
// item enters. Configuration writes to indices 6 and 7 are ignored.
module cube_map_face_select #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    cmfs_dir_if.sink    dir_in,
    cmfs_res_if.source  res_out
);
    import cmfs_pkg::*;

    localparam int QW = COORD_FRAC_BITS;
    localparam int CW = COORD_FRAC_BITS + 1;
    localparam logic [CW-1:0] HALF = CW'(1) << (COORD_FRAC_BITS - 1);

    logic [ADDR_W-1:0] base_reg [NUM_FACES];
    sel_t              sel;
    logic              en;
    logic              stg_valid [QW+1];
    work_t             stg_work  [QW+1];
    logic [QW-1:0]     stg_q_s   [QW+1];
    logic [QW-1:0]     stg_q_t   [QW+1];
    logic              out_valid_reg;
    logic [COORD_W-1:0] coord_s_reg;
    logic [COORD_W-1:0] coord_t_reg;
    logic [DIR_W-1:0]  major_reg;
    logic [FACE_W-1:0] face_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [COORD_W-1:0] coord_s_next;
    logic [COORD_W-1:0] coord_t_next;
    logic [CW-1:0]     raw_s;
    logic [CW-1:0]     raw_t;
    work_t             last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FACES; i++)
                base_reg[i] <= '0;
        end
        else if (cfg_we && cfg_index < 3'(NUM_FACES))
        begin
            base_reg[cfg_index] <= cfg_data;
        end
    end

    // Pipeline advance
    assign en           = !(out_valid_reg && !res_out.ready);
    assign dir_in.ready = en;

    cmfs_face_sel u_face_sel (
        .dir_u (dir_in.dir_u),
        .dir_v (dir_in.dir_v),
        .dir_w (dir_in.dir_w),
        .sel   (sel)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid[0] <= 1'b0;
        else if (en)
            stg_valid[0] <= dir_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_work[0].rem_s   <= sel.mag_x;
            stg_work[0].rem_t   <= sel.mag_y;
            stg_work[0].divisor <= sel.mag_z;
            stg_work[0].neg_s   <= sel.neg_s;
            stg_work[0].neg_t   <= sel.neg_t;
            stg_work[0].face    <= sel.face;
            stg_work[0].addr    <= base_reg[sel.face];
        end
    end

    assign stg_q_s[0] = '0;
    assign stg_q_t[0] = '0;

    // Division chain
    for (genvar g = 0; g < QW; g++)
    begin : g_cell
        cmfs_div_cell #(
            .QW    (QW),
            .FIRST (g == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (stg_valid[g]),
            .work_in   (stg_work[g]),
            .q_s_in    (stg_q_s[g]),
            .q_t_in    (stg_q_t[g]),
            .valid_out (stg_valid[g+1]),
            .work_out  (stg_work[g+1]),
            .q_s_out   (stg_q_s[g+1]),
            .q_t_out   (stg_q_t[g+1])
        );
    end

    // Recombine: half plus or minus quotient, saturate to the field
    assign last = stg_work[QW];

    always_comb
    begin
        if (last.divisor == '0)
        begin
            raw_s = HALF;
            raw_t = HALF;
        end
        else
        begin
            raw_s = last.neg_s ? HALF - {1'b0, stg_q_s[QW]} : HALF + {1'b0, stg_q_s[QW]};
            raw_t = last.neg_t ? HALF - {1'b0, stg_q_t[QW]} : HALF + {1'b0, stg_q_t[QW]};
        end
        if (CW > COORD_W && raw_s > CW'(COORD_MAX))
            coord_s_next = COORD_MAX;
        else
            coord_s_next = COORD_W'(raw_s);
        if (CW > COORD_W && raw_t > CW'(COORD_MAX))
            coord_t_next = COORD_MAX;
        else
            coord_t_next = COORD_W'(raw_t);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= stg_valid[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_s_reg <= coord_s_next;
            coord_t_reg <= coord_t_next;
            major_reg   <= last.divisor;
            face_reg    <= last.face;
            addr_reg    <= last.addr;
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.coord_s      = coord_s_reg;
    assign res_out.coord_t      = coord_t_reg;
    assign res_out.major_abs    = major_reg;
    assign res_out.face_index   = face_reg;
    assign res_out.face_address = addr_reg;

`ifndef NO_ASSERTIONS
    // Back-pressure only ever comes from a held output item
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !dir_in.ready |-> res_out.valid && !res_out.ready)
        else $error("input stalled without a held output item");

    // A zero major axis is only the zero vector: face -Z at one half
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.major_abs == '0 |->
            res_out.face_index == FACE_NZ && res_out.coord_s == COORD_W'(HALF)
            && res_out.coord_t == COORD_W'(HALF))
        else $error("zero vector result wrong");

    // Face code stays within the six faces
    a_face: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> res_out.face_index <= FACE_NZ)
        else $error("face index out of range");

    // A write to the +X base lands in its register
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == FACE_PX |=> base_reg[0] == $past(cfg_data))
        else $error("base register write lost");
`endif

endmodule

FILE: rtl/cmfs_face_sel.sv
// Major-axis selection and per-face remapping of the minor components.
`timescale 1ns / 1ps
module cmfs_face_sel (
    input  logic signed [23:0] dir_u,
    input  logic signed [23:0] dir_v,
    input  logic signed [23:0] dir_w,
    output cmfs_pkg::sel_t     sel
);
    import cmfs_pkg::*;

    logic [DIR_W-1:0] au;
    logic [DIR_W-1:0] av;
    logic [DIR_W-1:0] aw;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;

    // Magnitudes; the most negative value maps to 2^23
    assign au = dir_u[23] ? (~dir_u + 24'd1) : dir_u;
    assign av = dir_v[23] ? (~dir_v + 24'd1) : dir_v;
    assign aw = dir_w[23] ? (~dir_w + 24'd1) : dir_w;

    // Strict compares: ties fall through to the later axis
    always_comb
    begin
        if (au > av && au > aw)
        begin
            sel.face  = (!dir_u[23] && au != '0) ? FACE_PX : FACE_NX;
            sel.mag_x = aw;
            sel.mag_y = av;
            sel.mag_z = au;
            neg_x     = !dir_w[23];
            neg_y     = (sel.face == FACE_PX) ? !dir_v[23] : dir_v[23];
            neg_z     = dir_u[23];
        end
        else if (av > aw)
        begin
            sel.face  = (!dir_v[23] && av != '0) ? FACE_PY : FACE_NY;
            sel.mag_x = au;
            sel.mag_y = aw;
            sel.mag_z = av;
            neg_x     = (sel.face == FACE_PY) ? dir_u[23] : !dir_u[23];
            neg_y     = dir_w[23];
            neg_z     = dir_v[23];
        end
        else
        begin
            sel.face  = (!dir_w[23] && aw != '0) ? FACE_PZ : FACE_NZ;
            sel.mag_x = au;
            sel.mag_y = av;
            sel.mag_z = aw;
            neg_x     = dir_u[23];
            neg_y     = (sel.face == FACE_PZ) ? !dir_v[23] : dir_v[23];
            neg_z     = dir_w[23];
        end
        // result sign of minor / major
        sel.neg_s = neg_x ^ neg_z;
        sel.neg_t = neg_y ^ neg_z;
    end

endmodule

FILE: rtl/cmfs_div_cell.sv
// One restoring-division cell: yields one quotient bit for s and t per item.
`timescale 1ns / 1ps
module cmfs_div_cell #(
    parameter int QW    = 16,
    parameter bit FIRST = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  cmfs_pkg::work_t       work_in,
    input  logic [QW-1:0]         q_s_in,
    input  logic [QW-1:0]         q_t_in,
    output logic                  valid_out,
    output cmfs_pkg::work_t       work_out,
    output logic [QW-1:0]         q_s_out,
    output logic [QW-1:0]         q_t_out
);
    import cmfs_pkg::*;

    logic [DIR_W:0]   trial_s;
    logic [DIR_W:0]   trial_t;
    logic             bit_s;
    logic             bit_t;
    logic [DIR_W:0]   diff_s;
    logic [DIR_W:0]   diff_t;
    logic             valid_reg;
    work_t            work_reg;
    work_t            work_next;
    logic [QW-1:0]    q_s_reg;
    logic [QW-1:0]    q_t_reg;

    // Trial subtract; the first cell compares without a shift
    always_comb
    begin
        trial_s = FIRST ? {1'b0, work_in.rem_s} : {work_in.rem_s, 1'b0};
        trial_t = FIRST ? {1'b0, work_in.rem_t} : {work_in.rem_t, 1'b0};
        diff_s  = trial_s - {1'b0, work_in.divisor};
        diff_t  = trial_t - {1'b0, work_in.divisor};
        bit_s   = trial_s >= {1'b0, work_in.divisor};
        bit_t   = trial_t >= {1'b0, work_in.divisor};
        work_next       = work_in;
        // remainder stays below the divisor, so 24 bits hold it
        work_next.rem_s = bit_s ? diff_s[DIR_W-1:0] : trial_s[DIR_W-1:0];
        work_next.rem_t = bit_t ? diff_t[DIR_W-1:0] : trial_t[DIR_W-1:0];
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
            q_s_reg  <= {q_s_in[QW-2:0], bit_s};
            q_t_reg  <= {q_t_in[QW-2:0], bit_t};
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;
    assign q_s_out   = q_s_reg;
    assign q_t_out   = q_t_reg;

endmodule
